@@ design/emf_pkg.sv @@
// Shared types and constants for the multichannel echo median filter.
// No dependencies; every other file refers to it by scoped names.
package emf_pkg;

    // Window and channel count
    localparam int WINDOW   = 5;
    localparam int CHANNELS = 4;
    localparam int MID      = WINDOW / 2;

    // Field widths
    localparam int CH_W   = 2;
    localparam int US_W   = 20;
    localparam int CM_W   = 15;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ROW_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Stream byte-padded widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // cm = floor(us / 29 / 2) = floor(us / 58), done as multiply by rounded-up reciprocal
    localparam int US_PER_CM  = 29;
    localparam int ROUND_TRIP = 2;
    localparam int CM_DIVISOR = US_PER_CM * ROUND_TRIP;
    localparam int DIV_SHIFT  = 27;
    localparam int RECIP_W    = 22;
    localparam int PROD_W     = US_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'((2 ** DIV_SHIFT + CM_DIVISOR - 1) / CM_DIVISOR);

    typedef logic [CH_W-1:0]   channel_t;
    typedef logic [US_W-1:0]   us_t;
    typedef logic [CM_W-1:0]   cm_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef cm_t [WINDOW-1:0]  ring_t;

endpackage

@@ design/emf_us_to_cm.sv @@
// Echo time to centimetre conversion: floor(us / 58) by reciprocal multiply.
// Depends on emf_pkg.
module emf_us_to_cm
(
    input  emf_pkg::us_t echo_us,
    output emf_pkg::cm_t dist_cm
);

    logic [emf_pkg::PROD_W-1:0] prod;

    // reciprocal error times max input stays below 2^DIV_SHIFT, so the floor is exact
    assign prod = {{emf_pkg::RECIP_W{1'b0}}, echo_us}
                * {{emf_pkg::US_W{1'b0}}, emf_pkg::DIV_RECIP};

    assign dist_cm = prod[emf_pkg::DIV_SHIFT +: emf_pkg::CM_W];

endmodule

@@ design/emf_median.sv @@
// Median of one window: rank every entry in descending order, pick rank WINDOW/2.
// Depends on emf_pkg.
module emf_median
(
    input  emf_pkg::ring_t ring,
    output emf_pkg::cm_t   median
);

    emf_pkg::slot_t rank [emf_pkg::WINDOW];

    // ties broken by position, so ranks form a permutation
    always_comb
    begin
        for (int i = 0; i < emf_pkg::WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < emf_pkg::WINDOW; j++)
            begin
                if ((ring[j] > ring[i]) || ((ring[j] == ring[i]) && (j < i)))
                begin
                    rank[i] = rank[i] + emf_pkg::slot_t'(1);
                end
            end
        end
    end

    always_comb
    begin
        median = '0;
        for (int i = 0; i < emf_pkg::WINDOW; i++)
        begin
            if (rank[i] == emf_pkg::slot_t'(emf_pkg::MID))
            begin
                median = ring[i];
            end
        end
    end

endmodule

@@ design/multichannel_echo_median_filter.sv @@
// Multichannel echo median filter: top level with the pipeline and per-channel windows.
// Depends on emf_pkg, emf_us_to_cm and emf_median.
//
// Each request carries one echo time (us) and a sensor channel. The block converts the
// time to whole centimetres as floor(us / 58), writes it over the oldest of the channel's
// last WINDOW readings and returns the channel together with the median of that window
// (lower middle value for an even window). Windows start all zero after reset and the
// zero slots count in the median until overwritten. A channel at or above CHANNELS
// changes nothing and returns median 0. The path is three registers deep: input
// register, conversion register, result register. One request is taken every cycle;
// only back-pressure on the result side slows it, and each stage keeps filling while
// the result register waits. Requests for the same channel back to back are fine: the
// window is updated in the same cycle the median is registered.
module multichannel_echo_median_filter
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [emf_pkg::S_DATA_W-1:0]    s_tdata,   // [19:0] echo_us, rest zero
    input  logic [emf_pkg::CH_W-1:0]        s_tuser,   // [1:0] channel

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [emf_pkg::M_DATA_W-1:0]    m_tdata,   // [14:0] median_cm, [15] zero
    output logic [emf_pkg::CH_W-1:0]        m_tuser    // [1:0] out_channel
);

    // stage 1: input register
    logic              s1_valid_reg;
    emf_pkg::channel_t s1_channel_reg;
    emf_pkg::us_t      s1_us_reg;

    // stage 2: converted distance
    logic              s2_valid_reg;
    emf_pkg::channel_t s2_channel_reg;
    emf_pkg::cm_t      s2_cm_reg;

    // result register
    logic              out_valid_reg;
    emf_pkg::channel_t out_channel_reg;
    emf_pkg::cm_t      out_median_reg;

    // per-channel windows and write pointers
    emf_pkg::ring_t    ring_reg [emf_pkg::CHANNELS];
    emf_pkg::slot_t    slot_reg [emf_pkg::CHANNELS];

    logic              out_free;
    logic              s2_free;
    logic              s1_free;
    logic              s2_adv;
    logic              ch_ok;
    emf_pkg::row_t     row;
    emf_pkg::slot_t    cur_slot;
    emf_pkg::slot_t    slot_next;
    emf_pkg::ring_t    ring_next;
    emf_pkg::cm_t      conv_cm;
    emf_pkg::cm_t      win_median;

    // flow control: a stage loads when it is empty or its content moves on
    assign out_free = !out_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s_tready = s1_free;

    emf_us_to_cm u_conv
    (
        .echo_us (s1_us_reg),
        .dist_cm (conv_cm)
    );

    // window lookup with the new sample already in place
    assign ch_ok = 32'(s2_channel_reg) < 32'(emf_pkg::CHANNELS);
    assign row   = emf_pkg::row_t'(s2_channel_reg);

    always_comb
    begin
        cur_slot  = slot_reg[row];
        ring_next = ring_reg[row];
        ring_next[cur_slot] = s2_cm_reg;
        if (cur_slot >= emf_pkg::slot_t'(emf_pkg::WINDOW - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = cur_slot + emf_pkg::slot_t'(1);
        end
    end

    emf_median u_median
    (
        .ring   (ring_next),
        .median (win_median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s1_free)
        begin
            s1_channel_reg <= s_tuser;
            s1_us_reg      <= s_tdata[emf_pkg::US_W-1:0];
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_channel_reg <= s1_channel_reg;
            s2_cm_reg      <= conv_cm;
        end
        if (s2_adv)
        begin
            out_channel_reg <= s2_channel_reg;
            out_median_reg  <= ch_ok ? win_median : '0;
        end
    end

    // window state, cleared at reset (model windows start all zero)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < emf_pkg::CHANNELS; c++)
            begin
                ring_reg[c] <= '0;
                slot_reg[c] <= '0;
            end
        end
        else if (s2_adv && ch_ok)
        begin
            ring_reg[row] <= ring_next;
            slot_reg[row] <= slot_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_channel_reg;
    assign m_tdata  = {{(emf_pkg::M_DATA_W - emf_pkg::CM_W){1'b0}}, out_median_reg};

endmodule

@@ dv/emf_scoreboard.sv @@
// Scoreboard for the multichannel echo median filter: predicts each median and checks results.
// Depends on emf_pkg for field types, window size, channel count and conversion constants.
package emf_tb_pkg;

    typedef struct packed {
        emf_pkg::channel_t ch;
        emf_pkg::cm_t      median;
    } median_rec_t;

    class echo_median_scoreboard;
        emf_pkg::cm_t  window_cm [emf_pkg::CHANNELS][emf_pkg::WINDOW];
        int unsigned   next_slot [emf_pkg::CHANNELS];
        median_rec_t   median_due [$];
        int unsigned   mismatches;

        function new();
            foreach (window_cm[c, k]) window_cm[c][k] = '0;
            foreach (next_slot[c]) next_slot[c] = 0;
            mismatches = 0;
        endfunction

        // floor(us / 29 / 2), kept to the distance width
        function emf_pkg::cm_t echo_to_cm(emf_pkg::us_t us);
            int unsigned q;
            q = us;
            q = (q / emf_pkg::US_PER_CM) / emf_pkg::ROUND_TRIP;
            return emf_pkg::cm_t'(q);
        endfunction

        // descending insertion sort of one channel's window, middle entry
        function emf_pkg::cm_t window_median(int ch);
            emf_pkg::cm_t sorted [emf_pkg::WINDOW];
            emf_pkg::cm_t v;
            int j;
            for (int i = 0; i < emf_pkg::WINDOW; i++) sorted[i] = window_cm[ch][i];
            for (int i = 1; i < emf_pkg::WINDOW; i++) begin
                v = sorted[i];
                j = i - 1;
                while (j >= 0 && sorted[j] < v) begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = v;
            end
            return sorted[emf_pkg::MID];
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        // called for every accepted request
        function void note_echo(emf_pkg::channel_t ch, emf_pkg::us_t us);
            median_rec_t rec;
            int c;
            c = ch;
            rec.ch = ch;
            rec.median = '0;
            if (c < emf_pkg::CHANNELS) begin
                window_cm[c][next_slot[c]] = echo_to_cm(us);
                next_slot[c] = (next_slot[c] + 1 >= emf_pkg::WINDOW) ? 0 : next_slot[c] + 1;
                rec.median = window_median(c);
            end
            median_due.push_back(rec);
        endfunction

        // called for every accepted result
        function void check_median(emf_pkg::channel_t ch, emf_pkg::cm_t median);
            median_rec_t rec;
            if (median_due.size() == 0) begin
                flag($sformatf("unexpected result: channel %0d median %0d", ch, median));
                return;
            end
            rec = median_due.pop_front();
            if (ch !== rec.ch)
                flag($sformatf("channel mismatch: expected %0d actual %0d", rec.ch, ch));
            if (median !== rec.median)
                flag($sformatf("median mismatch on channel %0d: expected %0d actual %0d",
                               rec.ch, rec.median, median));
        endfunction

        function int outstanding();
            return median_due.size();
        endfunction

        function int unsigned failures();
            return mismatches;
        endfunction
    endclass

endpackage

@@ dv/multichannel_echo_median_filter_tb.sv @@
// Testbench top for the multichannel echo median filter: directed then random echo requests.
// Depends on emf_pkg, emf_tb_pkg (scoreboard) and the block's RTL.
module multichannel_echo_median_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_REQS = 850;
    localparam emf_pkg::us_t US_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [emf_pkg::S_DATA_W-1:0] s_tdata = '0;   // [19:0] echo_us, rest zero
    logic [emf_pkg::CH_W-1:0]     s_tuser = '0;   // [1:0] channel

    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [emf_pkg::M_DATA_W-1:0] m_tdata;        // [14:0] median_cm, [15] zero
    logic [emf_pkg::CH_W-1:0]     m_tuser;        // [1:0] out_channel

    emf_tb_pkg::echo_median_scoreboard sb;

    int unsigned cycles = 0;
    int unsigned rx_hold = 0;
    int unsigned rx_done = 0;
    bit          rx_calm = 1'b0;

    multichannel_echo_median_filter u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watchdog: the slowest legal run needs only a small fraction of this
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: check every accepted result, then draw a random stall, possibly none, before the next.
    // Every so often the stall is switched off for a stretch of results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_median(m_tuser, m_tdata[emf_pkg::CM_W-1:0]);
                rx_done++;
                if (rx_done % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
                rx_hold = rx_calm ? 0 : $urandom_range(0, 15);
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // One request: stay idle over the given gap, then hold valid until taken.
    // Valid is left high after the handshake so a zero-gap request follows back to back.
    task automatic send_req(input emf_pkg::channel_t ch, input emf_pkg::us_t us,
                            input int unsigned gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= emf_pkg::S_DATA_W'(us);
        do @(posedge clk); while (!s_tready);
        sb.note_echo(ch, us);
    endtask

    // Stop sending and wait for every outstanding median
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // Echo mix: full range, realistic distances, cm boundaries, and a few values that tie
    function automatic emf_pkg::us_t pick_echo();
        int unsigned cm;
        case ($urandom_range(0, 9))
            0, 1, 2:    return emf_pkg::us_t'($urandom_range(0, 20'hFFFFF));
            3, 4, 5, 6: return emf_pkg::us_t'($urandom_range(0, 400 * emf_pkg::CM_DIVISOR));
            7, 8:
            begin
                cm = $urandom_range(0, 18077);
                return emf_pkg::us_t'(cm * emf_pkg::CM_DIVISOR +
                                      ($urandom_range(0, 1) ? emf_pkg::CM_DIVISOR - 1 : 0));
            end
            default:    return emf_pkg::us_t'($urandom_range(0, 2) * 2900);
        endcase
    endfunction

    initial
    begin
        bit tx_calm;
        sb = new();
        tx_calm = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Channel 0: zero, full scale, both sides of the first two cm steps, then wrap
        // so the oldest slot gets overwritten. Early medians include the cleared slots.
        send_req(0, 0, 0);
        send_req(0, US_MAX, 0);
        send_req(0, 57, 1);
        send_req(0, 58, 0);
        send_req(0, 115, 3);
        send_req(0, 116, 0);
        // Channel 1: full scale back to back, then zeros, which leave the median at full scale
        send_req(1, US_MAX, 0);
        send_req(1, US_MAX, 0);
        send_req(1, US_MAX, 0);
        send_req(1, 0, 0);
        send_req(1, 0, 0);
        // Channels 2 and 3 interleaved: ties on 2, alternating bit patterns on 3
        send_req(2, 5800, 2);
        send_req(3, 20'hAAAAA, 0);
        send_req(2, 5857, 0);
        send_req(3, 20'h55555, 1);
        send_req(2, 5858, 0);
        send_req(3, 1000, 0);
        send_req(2, 5800, 4);
        send_req(3, 2000, 0);
        send_req(3, 3000, 0);
        send_req(3, 4000, 2);
        send_req(3, 5000, 0);
        send_req(3, 6000, 0);
        drain_results();

        for (int unsigned n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            // Let the pipeline empty completely once in the middle of the run
            if (n == RANDOM_REQS / 2) drain_results();
            send_req(emf_pkg::channel_t'($urandom_range(0, 3)), pick_echo(),
                     tx_calm ? 0 : $urandom_range(0, 15));
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.failures() == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
